// ----- hdl/smc_pkg.sv -----
// Shared types and codes for the shadow memory checker.
`timescale 1ns / 1ps
`default_nettype none
package smc_pkg;
   localparam logic [2:0] KIND_LOAD    = 3'd0;
   localparam logic [2:0] KIND_STORE   = 3'd1;
   localparam logic [2:0] KIND_RESERVE = 3'd2;
   localparam logic [2:0] KIND_MALLOC  = 3'd3;
   localparam logic [2:0] KIND_FREE    = 3'd4;

   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_BAD     = 3'd1;
   localparam logic [2:0] STAT_UNKNOWN = 3'd2;
   localparam logic [2:0] STAT_FULL    = 3'd3;
   localparam logic [2:0] STAT_RANGE   = 3'd4;

   localparam logic [1:0] BS_FREE  = 2'd0;
   localparam logic [1:0] BS_ALLOC = 2'd1;
   localparam logic [1:0] BS_INIT  = 2'd2;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] address;
      logic [16:0] length;
   } req_type_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [16:0] released_length;
   } rsp_type_type;

   // byte sweep operation
   typedef enum logic [1:0] {
      OP_CHECK_INIT,   // load: all must be initialized
      OP_STORE,        // allocated->initialized, then all initialized
      OP_MARK_ALLOC,   // unallocated->allocated
      OP_FREE_CHECK    // none may be unallocated
   } op_type;

   // controller -> datapath
   typedef struct packed {
      logic   start;   // begin sweep of held range
      op_type op;
      logic   clear;   // write unallocated over held range (free commit)
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic done;
      logic bad;
   } sts_type;
endpackage
`default_nettype wire

// ----- hdl/smc_ram.sv -----
// Generic single-port-write, one-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module smc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hdl/smc_datapath.sv -----
// Shadow byte sweep datapath: clearing pass, range sweeps, per-byte update.
`timescale 1ns / 1ps
`default_nettype none
module smc_datapath #(
   parameter int SHADOW_BYTES = 65536
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [15:0]      base,
   input  wire logic [16:0]      count,
   input  wire smc_pkg::cmd_type cmd,
   output smc_pkg::sts_type      sts,
   output logic                  init_done
);
   localparam int AW = $clog2(SHADOW_BYTES);

   // memory too large for per-entry valid flops: a clearing pass after reset
   // writes every entry unallocated instead.
   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // sweep: read phase issues addresses, write phase follows in the next cycle
   logic          run_ff, run_in;
   logic          wrap_ff, wrap_in;   // pipeline bubble flag
   smc_pkg::op_type op_ff, op_in;
   logic          clear_ff, clear_in;
   logic [16:0]   left_ff, left_in;   // reads still to issue
   logic [AW:0]   rd_ptr_ff, rd_ptr_in;
   logic          rv_ff, rv_in;       // read data valid next cycle
   logic [AW-1:0] ra_ff, ra_in;       // address of data in flight
   logic          bad_ff, bad_in;
   logic          done_ff, done_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [1:0]    wr_data, rd_data;
   logic [1:0]    nxt;

   smc_ram #(.WIDTH(2), .DEPTH(SHADOW_BYTES)) u_shadow (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_ptr_ff[AW-1:0]), .rd_data(rd_data));

   always_comb begin
      nxt = rd_data;
      bad_in = cmd.start ? 1'b0 : bad_ff;
      if (rv_ff && !clear_ff) begin
         case (op_ff)
            smc_pkg::OP_CHECK_INIT: if (rd_data != smc_pkg::BS_INIT) bad_in = 1'b1;
            smc_pkg::OP_STORE: begin
               if (rd_data == smc_pkg::BS_ALLOC) nxt = smc_pkg::BS_INIT;
               else if (rd_data != smc_pkg::BS_INIT) bad_in = 1'b1;
            end
            smc_pkg::OP_MARK_ALLOC: if (rd_data == smc_pkg::BS_FREE) nxt = smc_pkg::BS_ALLOC;
            smc_pkg::OP_FREE_CHECK: if (rd_data == smc_pkg::BS_FREE) bad_in = 1'b1;
            default: ;
         endcase
      end
      if (clear_ff) nxt = smc_pkg::BS_FREE;
   end

   always_comb begin
      wr_en = 1'b0; wr_addr = ra_ff; wr_data = nxt;
      if (clr_busy_ff) begin
         wr_en = 1'b1; wr_addr = clr_addr_ff; wr_data = smc_pkg::BS_FREE;
      end else if (rv_ff) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(SHADOW_BYTES - 1)) clr_busy_in = 1'b0;
      end
      run_in = run_ff; op_in = op_ff; clear_in = clear_ff;
      left_in = left_ff; rd_ptr_in = rd_ptr_ff;
      rv_in = 1'b0; ra_in = rd_ptr_ff[AW-1:0];
      done_in = 1'b0; wrap_in = 1'b0;
      if (cmd.start) begin
         run_in = 1'b1; op_in = cmd.op; clear_in = cmd.clear;
         left_in = count; rd_ptr_in = (AW+1)'(base);
      end else if (run_ff) begin
         if (left_ff != 17'd0) begin
            rv_in = 1'b1;
            left_in = left_ff - 1'b1;
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end else if (!rv_ff && !wrap_ff) begin
            run_in = 1'b0; done_in = 1'b1;
         end else begin
            wrap_in = rv_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1; clr_addr_ff <= '0;
         run_ff <= 1'b0; rv_ff <= 1'b0; done_ff <= 1'b0; wrap_ff <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in; clr_addr_ff <= clr_addr_in;
         run_ff <= run_in; rv_ff <= rv_in; done_ff <= done_in; wrap_ff <= wrap_in;
      end
      op_ff <= op_in; clear_ff <= clear_in; left_ff <= left_in;
      rd_ptr_ff <= rd_ptr_in; ra_ff <= ra_in; bad_ff <= bad_in;
   end

   assign sts.done = done_ff;
   assign sts.bad  = bad_ff;
   assign init_done = !clr_busy_ff;
endmodule
`default_nettype wire

// ----- hdl/smc_controller.sv -----
// Request controller: range check, allocation table, sweep sequencing.
`timescale 1ns / 1ps
`default_nettype none
module smc_controller #(
   parameter int SHADOW_BYTES  = 65536,
   parameter int ALLOC_ENTRIES = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  init_done,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire smc_pkg::req_type_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output smc_pkg::rsp_type_type      rsp_data,
   output logic [15:0]                base,
   output logic [16:0]                count,
   output smc_pkg::cmd_type           cmd,
   input  wire smc_pkg::sts_type      sts
);
   localparam int EW = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_LOOKUP, S_SCAN, S_SWEEP, S_CLEAR, S_REPLY
   } state_type;

   state_type state_ff;
   smc_pkg::req_type_type req_ff;
   logic [ALLOC_ENTRIES-1:0] valid_ff;
   logic [15:0] ebase_ff [ALLOC_ENTRIES];
   logic [16:0] elen_ff  [ALLOC_ENTRIES];
   logic [EW-1:0] idx_ff;            // table scan index
   logic          hit_ff, free_ok_ff;
   logic [EW-1:0] hit_idx_ff, free_idx_ff;
   logic [16:0]   count_ff;
   logic          rsp_valid_ff;
   smc_pkg::rsp_type_type res_ff;    // result being built
   smc_pkg::rsp_type_type rsp_ff;    // result on offer
   smc_pkg::cmd_type cmd_ff;

   logic [31:0] span;
   assign span = 32'(req_data.address) + 32'(req_data.length);

   assign req_stall = (state_ff != S_IDLE) || !init_done;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign base  = req_ff.address;
   assign count = count_ff;
   assign cmd   = cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= '0; rsp_valid_ff <= 1'b0;
         cmd_ff <= '{start: 1'b0, op: smc_pkg::OP_CHECK_INIT, clear: 1'b0};
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_valid && !req_stall) begin
               req_ff <= req_data; count_ff <= req_data.length;
               idx_ff <= '0; hit_ff <= 1'b0; free_ok_ff <= 1'b0;
               if (req_data.req_type <= smc_pkg::KIND_MALLOC &&
                   span > 32'(SHADOW_BYTES)) begin
                  res_ff <= '{status: smc_pkg::STAT_RANGE, released_length: 17'd0};
                  state_ff <= S_REPLY;
               end else begin
                  res_ff <= '{status: smc_pkg::STAT_OK, released_length: 17'd0};
                  case (req_data.req_type)
                     smc_pkg::KIND_LOAD: begin
                        cmd_ff <= '{start: 1'b1, op: smc_pkg::OP_CHECK_INIT, clear: 1'b0};
                        state_ff <= S_SWEEP;
                     end
                     smc_pkg::KIND_STORE: begin
                        cmd_ff <= '{start: 1'b1, op: smc_pkg::OP_STORE, clear: 1'b0};
                        state_ff <= S_SWEEP;
                     end
                     smc_pkg::KIND_RESERVE: begin
                        cmd_ff <= '{start: 1'b1, op: smc_pkg::OP_MARK_ALLOC, clear: 1'b0};
                        state_ff <= S_SWEEP;
                     end
                     smc_pkg::KIND_MALLOC, smc_pkg::KIND_FREE: state_ff <= S_LOOKUP;
                     default: state_ff <= S_REPLY;
                  endcase
               end
            end
            S_LOOKUP: begin
               // one entry a cycle: base match and lowest free slot
               if (valid_ff[idx_ff] && ebase_ff[idx_ff] == req_ff.address && !hit_ff) begin
                  hit_ff <= 1'b1; hit_idx_ff <= idx_ff;
               end
               if (!valid_ff[idx_ff] && !free_ok_ff) begin
                  free_ok_ff <= 1'b1; free_idx_ff <= idx_ff;
               end
               if (idx_ff == EW'(ALLOC_ENTRIES - 1)) state_ff <= S_SCAN;
               else idx_ff <= idx_ff + 1'b1;
            end
            S_SCAN: begin
               if (req_ff.req_type == smc_pkg::KIND_MALLOC) begin
                  if (!hit_ff && !free_ok_ff) begin
                     res_ff.status <= smc_pkg::STAT_FULL; state_ff <= S_REPLY;
                  end else begin
                     idx_ff <= hit_ff ? hit_idx_ff : free_idx_ff;
                     cmd_ff <= '{start: 1'b1, op: smc_pkg::OP_MARK_ALLOC, clear: 1'b0};
                     state_ff <= S_SWEEP;
                  end
               end else if (!hit_ff) begin
                  res_ff.status <= smc_pkg::STAT_UNKNOWN; state_ff <= S_REPLY;
               end else begin
                  idx_ff <= hit_idx_ff; count_ff <= elen_ff[hit_idx_ff];
                  cmd_ff <= '{start: 1'b1, op: smc_pkg::OP_FREE_CHECK, clear: 1'b0};
                  state_ff <= S_SWEEP;
               end
            end
            S_SWEEP: if (sts.done) begin
               state_ff <= S_REPLY;
               case (req_ff.req_type)
                  smc_pkg::KIND_MALLOC: begin
                     valid_ff[idx_ff] <= 1'b1;
                     ebase_ff[idx_ff] <= req_ff.address;
                     elen_ff[idx_ff]  <= req_ff.length;
                  end
                  smc_pkg::KIND_FREE: begin
                     if (sts.bad) res_ff.status <= smc_pkg::STAT_BAD;
                     else begin
                        cmd_ff <= '{start: 1'b1, op: smc_pkg::OP_FREE_CHECK, clear: 1'b1};
                        state_ff <= S_CLEAR;
                     end
                  end
                  default: if (sts.bad) res_ff.status <= smc_pkg::STAT_BAD;
               endcase
            end else begin
               cmd_ff.start <= 1'b0;
            end
            S_CLEAR: if (sts.done) begin
               valid_ff[idx_ff] <= 1'b0;
               res_ff.released_length <= count_ff;
               state_ff <= S_REPLY;
            end else begin
               cmd_ff.start <= 1'b0;
            end
            S_REPLY: if (!rsp_valid_ff) begin
               rsp_ff <= res_ff; rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- hdl/shadow_memory_checker_top.sv -----
// Top level of the shadow memory checker: controller plus shadow datapath.
// Sequence: a load, store or reserve sweeps its range; a malloc first scans the
//   allocation table, a free scans the table, sweeps the recorded length and then clears it.
// Throughput: one request at a time, one shadow byte a cycle.
// Reset: synchronous; a clearing pass over all SHADOW_BYTES entries then holds req_stall high.
`timescale 1ns / 1ps
`default_nettype none
module shadow_memory_checker_top #(
   parameter int SHADOW_BYTES  = 65536,
   parameter int ALLOC_ENTRIES = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire smc_pkg::req_type_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output smc_pkg::rsp_type_type      rsp_data
);
   // command and status between the sequencer and the shadow sweep
   smc_pkg::cmd_type cmd;
   smc_pkg::sts_type sts;
   logic [15:0] base;
   logic [16:0] count;
   logic        init_done;

   smc_controller #(.SHADOW_BYTES(SHADOW_BYTES), .ALLOC_ENTRIES(ALLOC_ENTRIES)) u_ctrl (
      .clock(clock), .reset(reset), .init_done(init_done),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .base(base), .count(count), .cmd(cmd), .sts(sts));

   smc_datapath #(.SHADOW_BYTES(SHADOW_BYTES)) u_dp (
      .clock(clock), .reset(reset), .base(base), .count(count),
      .cmd(cmd), .sts(sts), .init_done(init_done));
endmodule
`default_nettype wire
